// File: hw/rtl/isen_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isen_pkg: interrupt status/enable block definitions
// Register map constants, item opcodes and the decoded-offset bundle.
// ----------------------------------------------------------------------------
package isen_pkg;

	localparam int NUM_GROUPS = 7;
	localparam int NUM_EXTRA  = 3;
	localparam int OFF_W      = 14;
	localparam int DATA_W     = 32;
	localparam int SUM_W      = 6;

	// Group bases; each group spans status, enable, set, clear words
	localparam logic [OFF_W-1:0] GRP_BASE [NUM_GROUPS] = '{
		14'h000, 14'h080, 14'h700, 14'h710, 14'h780, 14'h7c0, 14'h7d0
	};
	localparam logic [OFF_W-1:0] XS_ADDR [NUM_EXTRA] = '{14'h1540, 14'h241c, 14'h0854};
	localparam logic [OFF_W-1:0] XE_ADDR [NUM_EXTRA] = '{14'h153c, 14'h2418, 14'h0850};

	// Group roles
	localparam int GRP_SUMMARY = 0;
	localparam int GRP_ERROR   = 3;

	localparam logic [DATA_W-1:0] HALF_LO = 32'h0000ffff;
	localparam logic [DATA_W-1:0] HALF_HI = 32'hffff0000;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_EVENT = 2'd2
	} op_t;

	// Word within a group
	typedef enum logic [1:0] {
		SUB_STATUS = 2'd0,
		SUB_ENABLE = 2'd1,
		SUB_SET    = 2'd2,
		SUB_CLEAR  = 2'd3
	} sub_t;

	typedef struct packed {
		logic [NUM_GROUPS-1:0] grp_sel;
		sub_t                  sub;
		logic [NUM_EXTRA-1:0]  xs_sel;
		logic [NUM_EXTRA-1:0]  xe_sel;
	} dec_t;

endpackage

// File: hw/rtl/interrupt_status_enable_block_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_status_enable_block_core: interrupt status/enable registers
// Word reads, writes and status events against seven register groups and
// three extra status/enable pairs, with error fold and interrupt summary.
//
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_stall    op, offset, write_value, reset_pin,
//                                      power_pin
// out      out  out_valid / out_stall  read_data, irq_out
//
// One item per cycle sustained while out_stall is low; an item's result passes
// through the input register, then the result register together with the
// register file update.
// The register file is written once per item in a single decode/mask pass.
// arst_n clears control and all interrupt registers; a raised reset_pin on
// an item clears the registers as that item passes.
// A stalled result holds; the input register keeps taking items until it is
// full and the result register cannot drain.
// ----------------------------------------------------------------------------
module interrupt_status_enable_block_core
	import isen_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        op,
	input  logic [OFF_W-1:0]  offset,
	input  logic [DATA_W-1:0] write_value,
	input  logic              reset_pin,
	input  logic              power_pin,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] read_data,
	output logic              irq_out
);

	// input register
	logic              valid_s1;
	op_t               op_s1;
	logic [OFF_W-1:0]  offset_s1;
	logic [DATA_W-1:0] val_s1;
	logic              rst_s1;
	logic              pwr_s1;

	// register file
	logic [DATA_W-1:0] gs_q [NUM_GROUPS];
	logic [DATA_W-1:0] ge_q [NUM_GROUPS];
	logic [DATA_W-1:0] xs_q [NUM_EXTRA];
	logic [DATA_W-1:0] xe_q [NUM_EXTRA];

	logic [DATA_W-1:0] gs_n [NUM_GROUPS];
	logic [DATA_W-1:0] ge_n [NUM_GROUPS];
	logic [DATA_W-1:0] xs_n [NUM_EXTRA];
	logic [DATA_W-1:0] xe_n [NUM_EXTRA];

	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic              irq_q;

	logic              advance;
	logic              in_xfer;
	dec_t              dec;
	logic [DATA_W-1:0] rd_n;
	logic [DATA_W-1:0] err;
	logic [DATA_W-1:0] act4;
	logic [DATA_W-1:0] act5;
	logic [SUM_W-1:0]  pend;
	logic              irq_n;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1     <= op_t'(op);
			offset_s1 <= offset;
			val_s1    <= write_value;
			rst_s1    <= reset_pin;
			pwr_s1    <= power_pin;
		end
	end

	// offset decode
	always_comb begin
		dec     = '0;
		dec.sub = sub_t'(offset_s1[3:2]);
		for (int g = 0; g < NUM_GROUPS; g++) begin
			dec.grp_sel[g] = (offset_s1[1:0] == 2'b00) &&
				(offset_s1[OFF_W-1:4] == GRP_BASE[g][OFF_W-1:4]);
		end
		for (int k = 0; k < NUM_EXTRA; k++) begin
			dec.xs_sel[k] = (offset_s1 == XS_ADDR[k]);
			dec.xe_sel[k] = (offset_s1 == XE_ADDR[k]);
		end
	end

	// read mux, from the registers as they stand before this item
	always_comb begin
		rd_n = '0;
		if (!rst_s1 && op_s1 == OP_READ) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				if (dec.grp_sel[g] && dec.sub == SUB_STATUS) rd_n = rd_n | gs_q[g];
				if (dec.grp_sel[g] && dec.sub == SUB_ENABLE) rd_n = rd_n | ge_q[g];
			end
			for (int k = 0; k < NUM_EXTRA; k++) begin
				if (dec.xs_sel[k]) rd_n = rd_n | xs_q[k];
				if (dec.xe_sel[k]) rd_n = rd_n | xe_q[k];
			end
		end
	end

	// register update, error fold and summary
	always_comb begin
		gs_n = gs_q;
		ge_n = ge_q;
		xs_n = xs_q;
		xe_n = xe_q;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (dec.grp_sel[g]) begin
				case (op_s1)
					OP_WRITE: begin
						unique case (dec.sub)
							SUB_STATUS: if (g != GRP_SUMMARY) gs_n[g] = gs_q[g] & ~val_s1;
							SUB_ENABLE: ge_n[g] = val_s1;
							SUB_SET:    ge_n[g] = ge_q[g] | val_s1;
							SUB_CLEAR:  ge_n[g] = ge_q[g] & ~val_s1;
							default:    ge_n[g] = ge_q[g];
						endcase
					end
					OP_EVENT: begin
						if (dec.sub == SUB_STATUS && g != GRP_SUMMARY)
							gs_n[g] = gs_q[g] | val_s1;
					end
					default: ;
				endcase
			end
		end
		for (int k = 0; k < NUM_EXTRA; k++) begin
			case (op_s1)
				OP_WRITE: begin
					if (dec.xs_sel[k]) xs_n[k] = xs_q[k] & ~val_s1;
					if (dec.xe_sel[k]) xe_n[k] = val_s1;
				end
				OP_EVENT: begin
					if (dec.xs_sel[k]) xs_n[k] = xs_q[k] | val_s1;
				end
				default: ;
			endcase
		end

		if (rst_s1) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				gs_n[g] = '0;
				ge_n[g] = '0;
			end
			for (int k = 0; k < NUM_EXTRA; k++) begin
				xs_n[k] = '0;
				xe_n[k] = '0;
			end
		end

		// fold enabled error bits into the error group status (sticky)
		act4     = gs_n[4] & ge_n[4];
		act5     = gs_n[5] & ge_n[5];
		err      = '0;
		err[1]   = |(act4 & HALF_LO);
		err[2]   = |(act4 & HALF_HI);
		err[17]  = |(act5 & HALF_LO);
		err[18]  = |(act5 & HALF_HI);
		err[20]  = |(gs_n[6] & ge_n[6]);
		gs_n[GRP_ERROR] = gs_n[GRP_ERROR] | err;

		pend    = '0;
		pend[0] = |(gs_n[1] & ge_n[1]);
		pend[1] = |(gs_n[2] & ge_n[2]) || |(gs_n[GRP_ERROR] & ge_n[GRP_ERROR]);
		pend[2] = |(xs_n[0] & xe_n[0]);
		pend[4] = |(xs_n[1] & xe_n[1]);
		pend[5] = |(xs_n[2] & xe_n[2]);
		gs_n[GRP_SUMMARY] = {{(DATA_W-SUM_W){1'b0}}, pend};

		irq_n = !rst_s1 && pwr_s1 && |(pend & ge_n[GRP_SUMMARY][SUM_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				gs_q[g] <= '0;
				ge_q[g] <= '0;
			end
			for (int k = 0; k < NUM_EXTRA; k++) begin
				xs_q[k] <= '0;
				xe_q[k] <= '0;
			end
		end else if (advance) begin
			gs_q <= gs_n;
			ge_q <= ge_n;
			xs_q <= xs_n;
			xe_q <= xe_n;
		end
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			irq_q       <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			irq_q       <= irq_n;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_n;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_out   = irq_q;

	// summary word only ever carries its defined bits
	a_summary_bits: assert property (@(posedge clk) disable iff (!arst_n)
		gs_q[GRP_SUMMARY][DATA_W-1:SUM_W] == '0 && !gs_q[GRP_SUMMARY][3])
		else $error("summary status has undefined bits set");

	// a held result blocks the input register from draining
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && valid_s1 |-> in_stall)
		else $error("input register advanced into a stalled result");

	// pending interrupt agrees with the stored summary and top enable
	a_irq_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && irq_q |-> |(gs_q[GRP_SUMMARY] & ge_q[GRP_SUMMARY]))
		else $error("interrupt raised without enabled summary bit");

	// a reset item leaves every register cleared
	a_pin_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rst_s1 |=> gs_q[1] == '0 && ge_q[GRP_SUMMARY] == '0 &&
			gs_q[GRP_ERROR] == '0 && xs_q[0] == '0 && xe_q[2] == '0 && !irq_q)
		else $error("reset pin did not clear the register file");

endmodule

// File: verif/tb_interrupt_status_enable_block_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interrupt_status_enable_block_core: interrupt register block testbench
// Drives reads, writes, status events and reset/power pin levels through the
// input channel and checks read data and interrupt level of every result
// against a cycle-free model of the register file, under random idle and stall.
// ----------------------------------------------------------------------------
module tb_interrupt_status_enable_block_core;
	import isen_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;

	// Summary bit positions
	localparam int SUM_GRP1  = 0;
	localparam int SUM_GRP23 = 1;
	localparam int SUM_X0    = 2;
	localparam int SUM_X1    = 4;
	localparam int SUM_X2    = 5;

	// Error bits folded into the error group status
	localparam int FOLD_G4_LO = 1;
	localparam int FOLD_G4_HI = 2;
	localparam int FOLD_G5_LO = 17;
	localparam int FOLD_G5_HI = 18;
	localparam int FOLD_G6    = 20;

	typedef enum logic [1:0] {
		HIT_NONE,
		HIT_GROUP,
		HIT_XSTAT,
		HIT_XEN
	} hit_t;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic              irq;
	} result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        op = OP_READ;
	logic [OFF_W-1:0]  offset = '0;
	logic [DATA_W-1:0] write_value = '0;
	logic              reset_pin = 1'b0;
	logic              power_pin = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [DATA_W-1:0] read_data;
	logic              irq_out;

	// Register file shadow, cleared like the block after reset
	logic [DATA_W-1:0] grp_stat [NUM_GROUPS] = '{default: '0};
	logic [DATA_W-1:0] grp_en   [NUM_GROUPS] = '{default: '0};
	logic [DATA_W-1:0] x_stat   [NUM_EXTRA]  = '{default: '0};
	logic [DATA_W-1:0] x_en     [NUM_EXTRA]  = '{default: '0};

	result_t pending_results [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int sent_count    = 0;
	int fail_count    = 0;
	int n_read        = 0;
	int n_write       = 0;
	int n_event       = 0;
	int n_noop        = 0;
	int n_reset       = 0;
	int n_checked     = 0;
	int n_irq_high    = 0;

	interrupt_status_enable_block_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.offset     (offset),
		.write_value(write_value),
		.reset_pin  (reset_pin),
		.power_pin  (power_pin),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.irq_out    (irq_out)
	);

	always #6 clk = ~clk;

	initial begin
		#3_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [OFF_W-1:0] grp_addr(input int g, input sub_t s);
		return GRP_BASE[g] + {s, 2'b00};
	endfunction

	// Apply one item to the shadow registers and return its result
	function automatic result_t apply_item(input logic [1:0] i_op, input logic [OFF_W-1:0] i_off,
		input logic [DATA_W-1:0] i_val, input logic i_rst, input logic i_pwr);
		hit_t              hit;
		int                idx;
		int                g;
		int                word;
		sub_t              sub;
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] act;
		logic [DATA_W-1:0] err;
		logic [DATA_W-1:0] pend;
		result_t           res;
		hit = HIT_NONE;
		idx = 0;
		sub = SUB_STATUS;
		rd = '0;
		if (i_rst) begin
			for (g = 0; g < NUM_GROUPS; g++) begin
				grp_stat[g] = '0;
				grp_en[g] = '0;
			end
			for (g = 0; g < NUM_EXTRA; g++) begin
				x_stat[g] = '0;
				x_en[g] = '0;
			end
		end else begin
			if (i_off[1:0] == 2'b00) begin
				for (g = NUM_GROUPS - 1; g >= 0; g--) begin
					if (int'(i_off) >= int'(GRP_BASE[g]) && int'(i_off) < int'(GRP_BASE[g]) + 16) begin
						hit = HIT_GROUP;
						idx = g;
						word = (int'(i_off) - int'(GRP_BASE[g])) >> 2;
						sub = sub_t'(word[1:0]);
					end
				end
				for (g = 0; g < NUM_EXTRA; g++) begin
					if (hit == HIT_NONE && i_off == XS_ADDR[g]) begin
						hit = HIT_XSTAT;
						idx = g;
					end else if (hit == HIT_NONE && i_off == XE_ADDR[g]) begin
						hit = HIT_XEN;
						idx = g;
					end
				end
			end
			case (i_op)
				OP_READ: begin
					if (hit == HIT_GROUP && sub == SUB_STATUS)
						rd = grp_stat[idx];
					else if (hit == HIT_GROUP && sub == SUB_ENABLE)
						rd = grp_en[idx];
					else if (hit == HIT_XSTAT)
						rd = x_stat[idx];
					else if (hit == HIT_XEN)
						rd = x_en[idx];
				end
				OP_WRITE: begin
					if (hit == HIT_GROUP) begin
						case (sub)
							SUB_STATUS: if (idx != GRP_SUMMARY) grp_stat[idx] &= ~i_val;
							SUB_ENABLE: grp_en[idx] = i_val;
							SUB_SET:    grp_en[idx] |= i_val;
							default:    grp_en[idx] &= ~i_val;
						endcase
					end else if (hit == HIT_XSTAT) begin
						x_stat[idx] &= ~i_val;
					end else if (hit == HIT_XEN) begin
						x_en[idx] = i_val;
					end
				end
				OP_EVENT: begin
					if (hit == HIT_GROUP && sub == SUB_STATUS && idx != GRP_SUMMARY)
						grp_stat[idx] |= i_val;
					else if (hit == HIT_XSTAT)
						x_stat[idx] |= i_val;
				end
				default: ;
			endcase
		end
		// Fold enabled error sources, then rebuild the summary
		err = '0;
		act = grp_stat[4] & grp_en[4];
		if ((act & HALF_LO) != 0) err[FOLD_G4_LO] = 1'b1;
		if ((act & HALF_HI) != 0) err[FOLD_G4_HI] = 1'b1;
		act = grp_stat[5] & grp_en[5];
		if ((act & HALF_LO) != 0) err[FOLD_G5_LO] = 1'b1;
		if ((act & HALF_HI) != 0) err[FOLD_G5_HI] = 1'b1;
		if ((grp_stat[6] & grp_en[6]) != 0) err[FOLD_G6] = 1'b1;
		grp_stat[GRP_ERROR] |= err;
		pend = '0;
		pend[SUM_GRP1] = (grp_stat[1] & grp_en[1]) != 0;
		pend[SUM_GRP23] = ((grp_stat[2] & grp_en[2]) != 0)
			|| ((grp_stat[GRP_ERROR] & grp_en[GRP_ERROR]) != 0);
		pend[SUM_X0] = (x_stat[0] & x_en[0]) != 0;
		pend[SUM_X1] = (x_stat[1] & x_en[1]) != 0;
		pend[SUM_X2] = (x_stat[2] & x_en[2]) != 0;
		grp_stat[GRP_SUMMARY] = pend;
		res.rd = i_rst ? '0 : rd;
		res.irq = !i_rst && i_pwr && ((pend & grp_en[GRP_SUMMARY]) != 0);
		return res;
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no expectation: read_data=%h irq_out=%b",
						read_data, irq_out);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					n_checked++;
					if (read_data !== want.rd) begin
						$error("read_data: expected %h, got %h", want.rd, read_data);
						fail_count++;
					end
					if (irq_out !== want.irq) begin
						$error("irq_out: expected %b, got %b", want.irq, irq_out);
						fail_count++;
					end
					if (want.irq) n_irq_high++;
				end
			end
			if (in_valid && !in_stall) begin
				pending_results.push_back(apply_item(op, offset, write_value, reset_pin, power_pin));
				if (reset_pin) n_reset++;
				case (op)
					OP_READ:  n_read++;
					OP_WRITE: n_write++;
					OP_EVENT: n_event++;
					default:  n_noop++;
				endcase
			end
		end
	end

	task automatic send_item(input logic [1:0] i_op, input logic [OFF_W-1:0] i_off,
		input logic [DATA_W-1:0] i_val, input logic i_rst, input logic i_pwr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= i_op;
		offset <= i_off;
		write_value <= i_val;
		reset_pin <= i_rst;
		power_pin <= i_pwr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
	endtask

	// Let the last transfer reach the queue before looking at it
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_value();
		int r;
		r = $urandom_range(99);
		if (r < 15) return 32'd1 << $urandom_range(31);
		if (r < 20) return '1;
		if (r < 25) return '0;
		return $urandom;
	endfunction

	task automatic test_group_registers();
		send_item(OP_READ, grp_addr(GRP_SUMMARY, SUB_STATUS), '0, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(GRP_SUMMARY, SUB_ENABLE), '1, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(1, SUB_ENABLE), '1, 1'b0, 1'b1);
		send_item(OP_EVENT, grp_addr(1, SUB_STATUS), 32'h8000_0001, 1'b0, 1'b1);
		// summary is recomputed: event and write on it leave no trace
		send_item(OP_EVENT, grp_addr(GRP_SUMMARY, SUB_STATUS), '1, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(GRP_SUMMARY, SUB_STATUS), '1, 1'b0, 1'b1);
		send_item(OP_READ, grp_addr(GRP_SUMMARY, SUB_STATUS), '0, 1'b0, 1'b1);
		send_item(OP_EVENT, grp_addr(1, SUB_ENABLE), 32'h0000_1234, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(1, SUB_STATUS), 32'h0000_0001, 1'b0, 1'b1);
		send_item(OP_READ, grp_addr(1, SUB_STATUS), '0, 1'b0, 1'b0);
		// error sources fold into the error group
		send_item(OP_WRITE, grp_addr(4, SUB_SET), 32'h0001_0001, 1'b0, 1'b1);
		send_item(OP_EVENT, grp_addr(4, SUB_STATUS), '1, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(5, SUB_ENABLE), 32'h0001_8000, 1'b0, 1'b1);
		send_item(OP_EVENT, grp_addr(5, SUB_STATUS), '1, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(6, SUB_SET), '1, 1'b0, 1'b1);
		send_item(OP_EVENT, grp_addr(6, SUB_STATUS), 32'h8000_0000, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(GRP_ERROR, SUB_ENABLE), '1, 1'b0, 1'b1);
		send_item(OP_READ, grp_addr(GRP_ERROR, SUB_STATUS), '0, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(4, SUB_CLEAR), '1, 1'b0, 1'b1);
	endtask

	task automatic test_extra_registers();
		int k;
		for (k = 0; k < NUM_EXTRA; k++) begin
			send_item(OP_WRITE, XE_ADDR[k], '1, 1'b0, 1'b1);
			send_item(OP_EVENT, XS_ADDR[k], 32'd1 << k, 1'b0, 1'b1);
		end
		send_item(OP_WRITE, XS_ADDR[NUM_EXTRA-1], '1, 1'b0, 1'b1);
	endtask

	task automatic test_special_items();
		send_item(OP_READ, 14'h2dff, '0, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(1, SUB_ENABLE) + 14'd2, '1, 1'b0, 1'b1);
		send_item(OP_NONE, grp_addr(1, SUB_STATUS), '1, 1'b0, 1'b1);
		send_item(OP_WRITE, grp_addr(1, SUB_SET), '1, 1'b1, 1'b1);
		send_item(OP_READ, grp_addr(GRP_SUMMARY, SUB_ENABLE), '0, 1'b0, 1'b1);
	endtask

	// Enable one source, raise it, look at summary and status, then clear it
	task automatic run_source_flow();
		int                src;
		logic [OFF_W-1:0]  stat_off;
		logic [OFF_W-1:0]  en_off;
		src = $urandom_range(8);
		if (src < 6) begin
			stat_off = grp_addr(src + 1, SUB_STATUS);
			en_off = grp_addr(src + 1, $urandom_range(1) ? SUB_SET : SUB_ENABLE);
		end else begin
			stat_off = XS_ADDR[src-6];
			en_off = XE_ADDR[src-6];
		end
		if ($urandom_range(4) == 0)
			send_item(OP_WRITE, grp_addr(GRP_SUMMARY, SUB_SET), $urandom, 1'b0, 1'b1);
		if (src >= 3 && src < 6 && $urandom_range(2) == 0)
			send_item(OP_WRITE, grp_addr(GRP_ERROR, SUB_SET), rand_value(), 1'b0, 1'b1);
		send_item(OP_WRITE, en_off, rand_value(), 1'b0, 1'b1);
		send_item(OP_EVENT, stat_off, rand_value(), 1'b0, 1'b1);
		send_item(OP_READ, grp_addr(GRP_SUMMARY, SUB_STATUS), '0, 1'b0, 1'b1);
		send_item(OP_READ, stat_off, '0, 1'b0, 1'b1);
		send_item(OP_WRITE, stat_off, rand_value(), 1'b0, 1'b1);
		if (src < 6 && $urandom_range(3) == 0)
			send_item(OP_WRITE, grp_addr(src + 1, SUB_CLEAR), rand_value(), 1'b0, 1'b1);
	endtask

	task automatic send_random_item();
		int               r;
		int               k;
		logic [1:0]       i_op;
		logic [OFF_W-1:0] i_off;
		r = $urandom_range(99);
		if (r < 35) i_op = OP_READ;
		else if (r < 65) i_op = OP_WRITE;
		else if (r < 97) i_op = OP_EVENT;
		else i_op = OP_NONE;
		r = $urandom_range(99);
		if (r < 80) begin
			k = $urandom_range(2);
			if ($urandom_range(33) < 28)
				i_off = grp_addr($urandom_range(NUM_GROUPS - 1), sub_t'($urandom_range(3)));
			else
				i_off = $urandom_range(1) ? XS_ADDR[k] : XE_ADDR[k];
		end else begin
			i_off = OFF_W'($urandom_range(11775));
			if (r < 90) i_off[1:0] = 2'b00;
		end
		send_item(i_op, i_off, rand_value(), $urandom_range(99) < 2, $urandom_range(99) < 90);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_in, input int quota);
		int first;
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		first = sent_count;
		while (sent_count - first < quota) begin
			if ($urandom_range(9) < 6)
				run_source_flow();
			else
				send_random_item();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_group_registers();
		test_extra_registers();
		test_special_items();
		wait_all_results();
		test_random_traffic(0, 0, 104);
		test_random_traffic(69, 0, 104);
		// hold the sender off until the block has drained
		wait_all_results();
		test_random_traffic(0, 69, 104);
		test_random_traffic(32, 32, 104);
		send_idle_pct = 0;
		stall_pct = 0;
		wait_all_results();
		repeat (10) @(posedge clk);
		$display("Covered %0d reads, %0d writes, %0d events, %0d no-op items, %0d pin resets",
			n_read, n_write, n_event, n_noop, n_reset);
		$display("Checked %0d results, %0d of them with the interrupt line high",
			n_checked, n_irq_high);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
